// ===== rtl/a85_pkg.sv =====
// a85_pkg: shared types, character codes and constants for the ascii85 stream decoder
// used by a85_front, a85_fifo, a85_back and ascii85_stream_decoder

package a85_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_Z    = 8'h7A;

    localparam logic [19:0] RADIX = 20'd85;
    localparam logic [2:0]  GROUP_LAST_DIGIT = 3'd4;

    // one queued group: bytes go out high first, last_idx is byte count minus one
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  last_idx;
        logic        done;
    } grp_t;

    // 85^(5 - cnt): padding with digit 84 is (v + 1) * 85^k - 1
    function automatic logic [19:0] pad_factor(input logic [2:0] cnt);
        logic [19:0] f;
        begin
            case (cnt)
                3'd2:    f = 20'd614125;
                3'd3:    f = 20'd7225;
                default: f = 20'd85;
            endcase
            return f;
        end
    endfunction

endpackage

// ===== rtl/a85_front.sv =====
// a85_front: accepts encoded characters, classifies them and runs the base-85 accumulator
// depends on a85_pkg; pushes finished groups into a85_fifo

module a85_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [7:0]       in_code,
    input  logic             in_eos,
    input  logic             q_full,
    output logic             in_ready,
    output logic             push,
    output a85_pkg::grp_t    push_data
);

    logic [31:0] group_value_reg, group_value_next;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [31:0] mul_a;
    logic [19:0] mul_b;
    logic [31:0] addend;
    logic [51:0] prod_full;
    logic [31:0] prod;
    logic [7:0]  digit;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign digit     = in_code - a85_pkg::CH_BANG;
    assign prod_full = {20'b0, mul_a} * {32'b0, mul_b};
    assign prod      = prod_full[31:0] + addend;

    always_comb begin
        if (in_eos) begin
            mul_a  = group_value_reg + 32'd1;
            mul_b  = a85_pkg::pad_factor(digit_count_reg);
            addend = '1;
        end else begin
            mul_a  = group_value_reg;
            mul_b  = a85_pkg::RADIX;
            addend = {24'b0, digit};
        end
    end

    always_comb begin
        group_value_next   = group_value_reg;
        digit_count_next   = digit_count_reg;
        halted_next        = halted_reg;
        push               = 1'b0;
        push_data.word     = prod;
        push_data.last_idx = 2'd3;
        push_data.done     = 1'b0;
        if (accept) begin
            if (in_eos) begin
                push               = (digit_count_reg >= 3'd2);
                push_data.last_idx = 2'(digit_count_reg - 3'd2);
                push_data.done     = 1'b1;
                group_value_next   = '0;
                digit_count_next   = '0;
                halted_next        = 1'b0;
            end else if (!halted_reg) begin
                if (in_code inside {a85_pkg::CH_TAB, a85_pkg::CH_LF,
                                    a85_pkg::CH_CR, a85_pkg::CH_SP}) begin
                    // whitespace skipped
                end else if (in_code == a85_pkg::CH_Z) begin
                    push             = 1'b1;
                    push_data.word   = '0;
                    group_value_next = '0;
                    digit_count_next = '0;
                end else if (in_code inside {[a85_pkg::CH_BANG:a85_pkg::CH_U]}) begin
                    if (digit_count_reg == a85_pkg::GROUP_LAST_DIGIT) begin
                        push             = 1'b1;
                        group_value_next = '0;
                        digit_count_next = '0;
                    end else begin
                        group_value_next = prod;
                        digit_count_next = digit_count_reg + 3'd1;
                    end
                end else begin
                    halted_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_value_reg <= '0;
            digit_count_reg <= '0;
            halted_reg      <= 1'b0;
        end else begin
            group_value_reg <= group_value_next;
            digit_count_reg <= digit_count_next;
            halted_reg      <= halted_next;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_count_reg <= a85_pkg::GROUP_LAST_DIGIT)
        else $error("digit count beyond a group");

    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && halted_reg && !in_eos) |-> !push && $stable(group_value_next))
        else $error("halted decoder produced a group");

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_eos) |=> (digit_count_reg == 3'd0) && !halted_reg)
        else $error("end word did not clear decoder state");

endmodule

// ===== rtl/a85_fifo.sv =====
// a85_fifo: short register queue of decoded groups between front and back
// depends on a85_pkg for grp_t and depth constants

module a85_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  a85_pkg::grp_t    push_data,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output a85_pkg::grp_t    pop_data
);

    a85_pkg::grp_t                 mem_reg [a85_pkg::FIFO_DEPTH];
    logic [a85_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [a85_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [a85_pkg::CNT_W-1:0]     count_reg, count_next;

    assign full     = (count_reg == a85_pkg::CNT_W'(a85_pkg::FIFO_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == a85_pkg::PTR_W'(a85_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + a85_pkg::PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == a85_pkg::PTR_W'(a85_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + a85_pkg::PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + a85_pkg::CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - a85_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("group queue overflow");

endmodule

// ===== rtl/a85_back.sv =====
// a85_back: takes queued groups and sends their bytes high first through an output register
// depends on a85_pkg for grp_t

module a85_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  a85_pkg::grp_t    q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic        busy_reg, busy_next;
    logic [31:0] word_reg, word_next;
    logic [1:0]  left_reg, left_next;
    logic        done_reg, done_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        m_tuser_reg, m_tuser_next;

    logic        out_free;
    logic        emit;
    logic        final_byte;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign emit       = busy_reg && out_free;
    assign final_byte = (left_reg == 2'd0);
    assign q_pop      = q_valid && (!busy_reg || (emit && final_byte));

    always_comb begin
        busy_next     = busy_reg;
        word_next     = word_reg;
        left_next     = left_reg;
        done_next     = done_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = word_reg[31:24];
            m_tlast_next  = final_byte;
            m_tuser_next  = done_reg && final_byte;
            word_next     = {word_reg[23:0], 8'h00};
            left_next     = left_reg - 2'd1;
            if (final_byte) begin
                busy_next = 1'b0;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (q_pop) begin
            busy_next = 1'b1;
            word_next = q_data.word;
            left_next = q_data.last_idx;
            done_next = q_data.done;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg    <= word_next;
        left_reg    <= left_next;
        done_reg    <= done_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> m_tlast_reg)
        else $error("stream done flag off the last byte of a group");

endmodule

// ===== rtl/ascii85_stream_decoder.sv =====
// ascii85_stream_decoder: top level of the streaming ascii85 decoder
// depends on a85_pkg, a85_front, a85_fifo and a85_back
//
// One encoded character is taken per word on the s_ side; s_tlast marks the end word, which
// flushes a partial group (padded with digit 84) and returns the decoder to its reset state.
// A character word is accepted in the cycle it arrives whenever the two-entry group queue has
// room; the front does its multiply-by-85 accumulate in that same cycle, so whitespace and
// digits stream at one word per clock while the queue has room. Each finished group (five
// digits, 'z' or a flush) is queued and sent out one byte per clock while m_tready allows,
// high byte first, from a registered output stage; five-digit groups are bound by their
// input words, while a run of 'z' words is bound by the byte side. The first byte of a group
// goes through the group queue, the word register and the output register. m_tlast marks the
// last byte caused by one input word, m_tuser the last byte of an end-of-stream flush.

module ascii85_stream_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] code_byte
    input  logic       s_tlast,   // end_of_stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tlast,   // last_in_run
    output logic       m_tuser    // [0] stream_done
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    a85_pkg::grp_t q_wdata;
    a85_pkg::grp_t q_rdata;

    a85_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_code   (s_tdata),
        .in_eos    (s_tlast),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (q_push),
        .push_data (q_wdata)
    );

    a85_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .pop_data  (q_rdata)
    );

    a85_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/tb_ascii85_stream_decoder.sv =====
// tb_ascii85_stream_decoder: self-checking testbench for the ascii85 stream decoder
// depends on a85_pkg and ascii85_stream_decoder; a scoreboard class predicts every decoded
// byte from the accepted words while plain tasks drive directed and random streams
`timescale 1ns / 1ps

module tb_ascii85_stream_decoder;

    localparam int          BASE      = 85;
    localparam int          PAD_DIGIT = 84;
    localparam logic [7:0]  CH_CLOSE  = 8'h3E;
    localparam int          LIMIT_NS  = 10_000_000;

    typedef struct {
        logic [7:0] data;
        bit         last;
        bit         done;
    } out_byte_t;

    class decode_scoreboard;
        logic [31:0] group_value;
        logic [2:0]  digit_count;
        bit          halted;
        out_byte_t   expected_bytes[$];
        int          errors;
        int          words_in;
        int          bytes_checked;
        int          streams_ended;
        int          halts;

        function new();
            clear_group();
            halted = 1'b0;
        endfunction

        function void clear_group();
            group_value = '0;
            digit_count = '0;
        endfunction

        function void push_bytes(logic [31:0] v, int nbytes, bit eos);
            out_byte_t b;
            for (int i = 0; i < nbytes; i++) begin
                b.data = v[8 * (3 - i) +: 8];
                b.last = (i == nbytes - 1);
                b.done = eos && (i == nbytes - 1);
                expected_bytes.push_back(b);
            end
        endfunction

        function void note_word(logic [7:0] code, logic eos);
            logic [31:0] v;
            words_in++;
            if (eos) begin
                streams_ended++;
                if (digit_count != 0) begin
                    v = group_value;
                    for (int i = digit_count; i < 5; i++)
                        v = v * BASE + PAD_DIGIT;
                    push_bytes(v, digit_count - 1, 1'b1);
                end
                clear_group();
                halted = 1'b0;
                return;
            end
            if (halted)
                return;
            if (code == a85_pkg::CH_TAB || code == a85_pkg::CH_LF ||
                code == a85_pkg::CH_CR || code == a85_pkg::CH_SP)
                return;
            if (code == a85_pkg::CH_Z) begin
                push_bytes(32'd0, 4, 1'b0);
                clear_group();
            end else if (code < a85_pkg::CH_BANG || code > a85_pkg::CH_U) begin
                halted = 1'b1;
                halts++;
            end else begin
                group_value = group_value * BASE + (code - a85_pkg::CH_BANG);
                digit_count = digit_count + 1;
                if (digit_count == 5) begin
                    push_bytes(group_value, 4, 1'b0);
                    clear_group();
                end
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last, logic done);
            out_byte_t e;
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte: data_byte %02h last_in_run %0b stream_done %0b",
                       data, last, done);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            bytes_checked++;
            if (data !== e.data) begin
                $error("data_byte: expected %02h, got %02h", e.data, data);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_in_run: expected %0b, got %0b", e.last, last);
                errors++;
            end
            if (done !== e.done) begin
                $error("stream_done: expected %0b, got %0b", e.done, done);
                errors++;
            end
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    int gap_pct   = 0;
    int stall_pct = 0;

    decode_scoreboard sb = new();

    ascii85_stream_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tlast, m_tuser);
        end
    end

    // byte side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_ascii85_stream_decoder: errors");
        $finish;
    end

    task automatic send_word(input logic [7:0] code, input bit eos);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(a85_pkg::CH_BANG + $urandom_range(0, BASE - 1));
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 3))
            0:       return a85_pkg::CH_TAB;
            1:       return a85_pkg::CH_LF;
            2:       return a85_pkg::CH_CR;
            default: return a85_pkg::CH_SP;
        endcase
    endfunction

    task automatic send_digit_spaced();
        if ($urandom_range(0, 7) == 0)
            send_word(rand_space(), 1'b0);
        send_word(rand_digit(), 1'b0);
    endtask

    task automatic send_random_stream();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 7) == 0)
                    send_word(a85_pkg::CH_Z, 1'b0);
                else
                    repeat (5) send_digit_spaced();
            end
            repeat ($urandom_range(0, 4)) send_digit_spaced();
        end else if (kind <= 8) begin
            repeat ($urandom_range(0, 7)) send_digit_spaced();
            send_word(8'($urandom_range(0, 255)), 1'b0);
            repeat ($urandom_range(0, 3)) send_word(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        send_end();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: wrapping group with every whitespace, zero run, 'z' mid-group,
        // flushes of three, one, zero and four digits, the last with '>' decoded as a digit
        send_text("u u\tu\ru\nu");
        send_text("z");
        send_text("!!z");
        send_text("!!!");
        send_end();
        send_text("u");
        send_end();
        send_end();
        send_word("u", 1'b0);
        send_word("u", 1'b0);
        send_word(CH_CLOSE, 1'b0);
        send_word("u", 1'b0);
        send_end();

        while (sb.words_in < 140) begin
            if (sb.words_in >= 110) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 20 * $urandom_range(0, 2);
                stall_pct = 20 * $urandom_range(0, 2);
            end
            send_random_stream();
        end
        s_tvalid <= 1'b0;

        while (sb.expected_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d words in %0d streams (%0d halted), %0d decoded bytes checked",
                 sb.words_in, sb.streams_ended, sb.halts, sb.bytes_checked);
        if (sb.errors == 0)
            $display("tb_ascii85_stream_decoder: clean");
        else
            $display("tb_ascii85_stream_decoder: errors");
        $finish;
    end

endmodule
